// ===== hw/rtl/indexed_value_list_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed value list assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_VALUE_LIST_UNIT_ASSERT_SVH
`define INDEXED_VALUE_LIST_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define IVL_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication
`define IVL_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define IVL_ASSERT_IMP(lbl, pre, post, msg)
`define IVL_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// ===== hw/rtl/ivl_pkg.sv =====
// ----------------------------------------------------------------------------
// ivl_pkg
// Types, codes and helpers shared by the indexed value list controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package ivl_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int FUNC_W        = 3;
	localparam int POS_W         = 8;
	localparam int VAL_W         = 32;
	localparam int SIZE_W        = 2;

	localparam logic [POS_W-1:0]  NO_POSITION = '1;
	localparam logic [VAL_W-1:0]  ALL_ONES    = '1;
	localparam logic [SIZE_W-1:0] SIZE_RESET  = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT  = 3'd0,
		FUNC_REPLACE = 3'd1,
		FUNC_REMOVE  = 3'd2,
		FUNC_READ    = 3'd3,
		FUNC_SEARCH  = 3'd4
	} func_t;

	typedef enum logic [SIZE_W-1:0] {
		SIZE_8  = 2'd0,
		SIZE_16 = 2'd1,
		SIZE_32 = 2'd2
	} size_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_UP_RD,
		ST_UP_WR,
		ST_DN_RD,
		ST_DN_WR,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_FIN_DONE,
		ST_FIN_FAIL,
		ST_FIN_READ,
		ST_FIN_FOUND
	} state_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_COUNT,
		PTR_POS,
		PTR_ZERO
	} ptr_load_t;

	typedef enum logic [1:0] {
		RD_PTR_DN,
		RD_PTR_UP,
		RD_PTR,
		RD_POS
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_DONE,
		RES_FAIL,
		RES_READ,
		RES_FOUND
	} res_kind_t;

	typedef struct packed {
		logic      load;
		ptr_load_t ptr_load;
		logic      ptr_inc;
		logic      ptr_dec;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_shift;
		logic      wr_value;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      res_load;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              ins_ok;
		logic              idx_ok;
		logic              up_more;
		logic              dn_more;
		logic              scan_more;
		logic              match;
		logic              out_free;
	} sts_t;

	function automatic logic [VAL_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
		logic [VAL_W-1:0] m;
		case (size)
			SIZE_8:  m = VAL_W'(32'h0000_00FF);
			SIZE_16: m = VAL_W'(32'h0000_FFFF);
			default: m = ALL_ONES;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/ivl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ivl_ctrl
// Request sequencer: decodes the held request and steps the datapath through
// shifts, scans and the final result load.
// ----------------------------------------------------------------------------
module ivl_ctrl import ivl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (sts.func)
					FUNC_INSERT:  state_d = sts.ins_ok ? ST_UP_RD : ST_FIN_FAIL;
					FUNC_REPLACE: state_d = sts.idx_ok ? ST_FIN_DONE : ST_FIN_FAIL;
					FUNC_REMOVE:  state_d = sts.idx_ok ? ST_DN_RD : ST_FIN_FAIL;
					FUNC_READ:    state_d = sts.idx_ok ? ST_FIN_READ : ST_FIN_FAIL;
					FUNC_SEARCH:  state_d = ST_SRCH_RD;
					default:      state_d = ST_FIN_FAIL;
				endcase
			end
			ST_UP_RD:    state_d = sts.up_more ? ST_UP_WR : ST_FIN_DONE;
			ST_UP_WR:    state_d = ST_UP_RD;
			ST_DN_RD:    state_d = sts.dn_more ? ST_DN_WR : ST_FIN_DONE;
			ST_DN_WR:    state_d = ST_DN_RD;
			ST_SRCH_RD:  state_d = sts.scan_more ? ST_SRCH_CMP : ST_FIN_FAIL;
			ST_SRCH_CMP: state_d = sts.match ? ST_FIN_FOUND : ST_SRCH_RD;
			ST_FIN_DONE, ST_FIN_FAIL, ST_FIN_READ, ST_FIN_FOUND: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.ptr_load = PTR_HOLD;
		cmd.rd_sel   = RD_PTR;
		cmd.res_kind = RES_DONE;
		in_stall     = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DECODE: begin
				case (sts.func)
					FUNC_INSERT: begin
						cmd.ptr_load = PTR_COUNT;
					end
					FUNC_REPLACE: begin
						cmd.wr_value = sts.idx_ok;
					end
					FUNC_REMOVE: begin
						cmd.ptr_load = PTR_POS;
					end
					FUNC_READ: begin
						cmd.rd_en  = sts.idx_ok;
						cmd.rd_sel = RD_POS;
					end
					FUNC_SEARCH: begin
						cmd.ptr_load = PTR_ZERO;
					end
					default: begin
						cmd.load = 1'b0;
					end
				endcase
			end
			ST_UP_RD: begin
				// fetch the entry below the hole, or drop the new value in
				if (sts.up_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_DN;
				end else begin
					cmd.wr_value = 1'b1;
					cmd.cnt_inc  = 1'b1;
				end
			end
			ST_UP_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_dec  = 1'b1;
			end
			ST_DN_RD: begin
				if (sts.dn_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_UP;
				end else begin
					cmd.cnt_dec = 1'b1;
				end
			end
			ST_DN_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
			end
			ST_SRCH_RD: begin
				cmd.rd_en  = sts.scan_more;
				cmd.rd_sel = RD_PTR;
			end
			ST_SRCH_CMP: begin
				cmd.ptr_inc = !sts.match;
			end
			ST_FIN_DONE: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_DONE;
			end
			ST_FIN_FAIL: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_FAIL;
			end
			ST_FIN_READ: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_READ;
			end
			ST_FIN_FOUND: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_FOUND;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ivl_dpath.sv =====
// ----------------------------------------------------------------------------
// ivl_dpath
// Entry memory, request and pointer registers, count, size register and the
// output register.
// ----------------------------------------------------------------------------
`include "indexed_value_list_unit_assert.svh"

module ivl_dpath import ivl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_valid,
	input  logic [SIZE_W-1:0] value_size,
	input  logic [FUNC_W-1:0] func,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [VAL_W-1:0]  value_out,
	output logic [POS_W-1:0]  found_position,
	output logic [CNT_W-1:0]  entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [VAL_W-1:0]  mem [DEPTH];
	logic [VAL_W-1:0]  rd_q;
	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] size_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [VAL_W-1:0]  value_out_q;
	logic [POS_W-1:0]  found_q;
	logic [CNT_W-1:0]  entry_count_q;

	logic [VAL_W-1:0]  mask;
	logic [CNT_W-1:0]  rd_ptr;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic [CNT_W:0]    ptr_nxt;
	logic              out_free;

	assign mask     = size_mask(size_q);
	assign out_free = !out_valid_q || !out_stall;
	assign ptr_nxt  = {1'b0, ptr_q} + 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR_DN: rd_ptr = ptr_q - 1'b1;
			RD_PTR_UP: rd_ptr = ptr_nxt[CNT_W-1:0];
			RD_PTR:    rd_ptr = ptr_q;
			default:   rd_ptr = CNT_W'(pos_q);
		endcase
	end

	assign rd_addr = rd_ptr[AW-1:0];
	assign wr_addr = cmd.wr_shift ? ptr_q[AW-1:0] : pos_q[AW-1:0];
	assign wr_data = cmd.wr_shift ? rd_q : (val_q & mask);

	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_value) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// hold the accepted request for the whole operation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			size_q  <= SIZE_RESET;
		end else begin
			case (cmd.ptr_load)
				PTR_COUNT: ptr_q <= count_q;
				PTR_POS:   ptr_q <= CNT_W'(pos_q);
				PTR_ZERO:  ptr_q <= '0;
				default: begin
					if (cmd.ptr_inc) begin
						ptr_q <= ptr_nxt[CNT_W-1:0];
					end else if (cmd.ptr_dec) begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
			endcase
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cfg_valid) begin
				size_q <= value_size;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			entry_count_q <= count_q;
			case (cmd.res_kind)
				RES_DONE: begin
					ok_q        <= 1'b1;
					value_out_q <= '0;
					found_q     <= NO_POSITION;
				end
				RES_READ: begin
					ok_q        <= 1'b1;
					value_out_q <= rd_q & mask;
					found_q     <= NO_POSITION;
				end
				RES_FOUND: begin
					ok_q        <= 1'b1;
					value_out_q <= rd_q & mask;
					found_q     <= POS_W'(ptr_q);
				end
				default: begin
					ok_q        <= 1'b0;
					value_out_q <= ALL_ONES;
					found_q     <= NO_POSITION;
				end
			endcase
		end
	end

	always_comb begin
		sts.func      = func_q;
		sts.ins_ok    = (pos_q <= POS_W'(count_q)) && (count_q < DEPTH_C);
		sts.idx_ok    = (pos_q < POS_W'(count_q));
		sts.up_more   = (POS_W'(ptr_q) > pos_q);
		sts.dn_more   = (ptr_nxt < {1'b0, count_q});
		sts.scan_more = (ptr_q < count_q);
		sts.match     = ((rd_q & mask) == val_q);
		sts.out_free  = out_free;
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign value_out      = value_out_q;
	assign found_position = found_q;
	assign entry_count    = entry_count_q;

	`IVL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DEPTH_C, "count beyond depth")
	`IVL_ASSERT_IMP(a_res_free, cmd.res_load, out_free, "result loaded over a waiting result")
	`IVL_ASSERT_NXT(a_cnt_inc, cmd.cnt_inc, count_q == CNT_W'($past(count_q) + 1'b1), "count did not advance")
	`IVL_ASSERT_IMP(a_wr_range, cmd.wr_shift, ptr_q < DEPTH_C, "shift write beyond depth")
	`IVL_ASSERT_IMP(a_wr_excl, cmd.wr_shift, !cmd.wr_value, "two write sources at once")

endmodule

// ===== hw/rtl/indexed_value_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_value_list_unit
// Ordered list of up to DEPTH values with insert, replace, remove, read and
// search requests; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (func, position, value_in) enter on in_valid / in_stall and are
//   taken at an edge with in_valid high and in_stall low. Results (ok,
//   value_out, found_position, entry_count) leave on out_valid / out_stall.
//   value_size is written over cfg_valid / cfg_ready; the user must do so only
//   while no request is open, as the block itself does not enforce it. One
//   request is worked at a time; entries live in a single-port style memory
//   with a registered read, and every moved entry takes a read step and a
//   write step, every scanned entry a read step and a compare step.
//   A new request is taken the cycle after the result is loaded, even while
//   that result is still held by out_stall; the next result then waits in
//   its final step until the output register frees up.
//   Reset empties the list and sets the value size to 32 bits; the memory
//   itself is not cleared.
// ----------------------------------------------------------------------------
module indexed_value_list_unit import ivl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] value_size,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [VAL_W-1:0]  value_out,
	output logic [POS_W-1:0]  found_position,
	output logic [CNT_W-1:0]  entry_count
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ivl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ivl_dpath #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.value_size     (value_size),
		.func           (func),
		.position       (position),
		.value_in       (value_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

endmodule

// ===== tb/sv/indexed_value_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed value list checker
// Watches the request, result and size-write channels, keeps its own copy of
// the list and the value size, predicts one result per accepted request and
// compares every returned result, field by field, in arrival order.
// ----------------------------------------------------------------------------
module indexed_value_list_checker import ivl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] value_size,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              ok,
	input  logic [VAL_W-1:0]  value_out,
	input  logic [POS_W-1:0]  found_position,
	input  logic [CNT_W-1:0]  entry_count,
	output int                mismatches,
	output int                pending,
	output int                checked,
	output int                search_hits
);

	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] where;
		logic [CNT_W-1:0] count;
	} list_result_t;

	logic [VAL_W-1:0]  cells [DEPTH];
	int                held;
	logic [SIZE_W-1:0] size_reg;
	list_result_t      awaited [$];
	int                errs;
	int                done;
	int                hits;

	// apply one request to the list copy and return what the block must answer
	function automatic list_result_t apply_request(logic [FUNC_W-1:0] op,
			logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		list_result_t     r;
		logic [VAL_W-1:0] keep;
		int               at;
		int               i;
		at = int'(pos);
		case (size_reg)
			SIZE_8:  keep = 32'h0000_00FF;
			SIZE_16: keep = 32'h0000_FFFF;
			default: keep = '1;
		endcase
		r.ok = 1'b0;
		r.value = ALL_ONES;
		r.where = NO_POSITION;
		case (op)
			FUNC_INSERT: begin
				if (at <= held && held < DEPTH) begin
					for (i = held; i > at; i--)
						cells[i] = cells[i - 1];
					cells[at] = val & keep;
					held++;
					r.ok = 1'b1;
					r.value = '0;
				end
			end
			FUNC_REPLACE: begin
				if (at < held) begin
					cells[at] = val & keep;
					r.ok = 1'b1;
					r.value = '0;
				end
			end
			FUNC_REMOVE: begin
				if (at < held) begin
					for (i = at; i + 1 < held; i++)
						cells[i] = cells[i + 1];
					held--;
					r.ok = 1'b1;
					r.value = '0;
				end
			end
			FUNC_READ: begin
				if (at < held) begin
					r.ok = 1'b1;
					r.value = cells[at] & keep;
				end
			end
			FUNC_SEARCH: begin
				// first match wins; a value wider than the size never matches
				for (i = 0; i < held; i++) begin
					if ((cells[i] & keep) == val) begin
						r.ok = 1'b1;
						r.value = cells[i] & keep;
						r.where = POS_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(held);
		return r;
	endfunction

	task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			size_reg = SIZE_RESET;
			awaited.delete();
			errs = 0;
			done = 0;
			hits = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("result returned with no request outstanding");
					errs++;
				end else begin
					want = awaited.pop_front();
					compare_field("ok", VAL_W'(want.ok), VAL_W'(ok));
					compare_field("value_out", want.value, value_out);
					compare_field("found_position", VAL_W'(want.where), VAL_W'(found_position));
					compare_field("entry_count", VAL_W'(want.count), VAL_W'(entry_count));
					if (want.where != NO_POSITION)
						hits++;
					done++;
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = value_size;
			if (in_valid && !in_stall)
				awaited.push_back(apply_request(func, position, value_in));
		end
		mismatches <= errs;
		pending <= awaited.size();
		checked <= done;
		search_hits <= hits;
	end

endmodule

// ===== tb/sv/indexed_value_list_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed value list unit testbench
// Directed corner requests, then random request streams that grow, churn and
// drain the list under changing value sizes, with random idle bursts on
// requests and stall bursts on results. Results are checked by the list checker.
// ----------------------------------------------------------------------------
module indexed_value_list_unit_test;
	import ivl_pkg::*;

	localparam int DEPTH      = DEPTH_DEFAULT;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int PHASES     = 8;
	localparam int PER_PHASE  = 240;
	localparam int CALM_TAIL  = 150;
	localparam int DRIFT_SPAN = 80;
	localparam int TAIL_WAIT  = 200;
	localparam int WATCHDOG   = 4000;

	localparam logic [SIZE_W-1:0] SIZE_SPARE     = 2'd3;
	localparam logic [FUNC_W-1:0] FUNC_BAD_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_BAD_LAST  = 3'd7;

	typedef enum logic [1:0] {
		DRIFT_GROW,
		DRIFT_MIX,
		DRIFT_SHRINK
	} drift_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] value_size;
	logic              in_valid;
	logic              in_stall;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value_in;
	logic              out_valid;
	logic              out_stall;
	logic              ok;
	logic [VAL_W-1:0]  value_out;
	logic [POS_W-1:0]  found_position;
	logic [CNT_W-1:0]  entry_count;

	int mismatches;
	int pending;
	int checked;
	int search_hits;

	int               list_len;
	int               peak_len;
	int               requests_sent;
	int               size_writes;
	int               idle_run;
	bit               calm;
	bit               stall_quiet;
	drift_t           drift;
	logic [VAL_W-1:0] pool [8];

	indexed_value_list_unit #(.DEPTH(DEPTH)) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.value_size     (value_size),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.position       (position),
		.value_in       (value_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	indexed_value_list_checker #(.DEPTH(DEPTH)) list_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.value_size     (value_size),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.position       (position),
		.value_in       (value_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.entry_count    (entry_count),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.search_hits    (search_hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: stall in bursts, none in quiet phases or once the run goes calm
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && !stall_quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// end the run if no channel moves for too long
	initial begin
		idle_run = 0;
		while (idle_run < WATCHDOG) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [VAL_W-1:0] v);
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		value_in <= v;
		do @(posedge clk); while (in_stall);
		// track the list length to steer positions
		if (f == FUNC_INSERT && int'(p) <= list_len && list_len < DEPTH)
			list_len++;
		else if (f == FUNC_REMOVE && int'(p) < list_len)
			list_len--;
		if (list_len > peak_len)
			peak_len = list_len;
		requests_sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// hold requests until every result is back
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] s);
		drain();
		cfg_valid <= 1'b1;
		value_size <= s;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_writes++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return pool[$urandom_range(0, 7)];
		if (roll < 55)
			return pool[$urandom_range(0, 7)] & 32'h0000_00FF;
		if (roll < 62)
			return pool[$urandom_range(0, 7)] & 32'h0000_FFFF;
		if (roll < 72) begin
			case ($urandom_range(0, 6))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h0000_00FF;
				3: return 32'h0000_FFFF;
				4: return 32'h0000_0100;
				5: return 32'h0001_0000;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom();
	endfunction

	task automatic random_request;
		int               roll;
		int               cut [5];
		logic [FUNC_W-1:0] f;
		logic [POS_W-1:0]  p;
		case (drift)
			DRIFT_GROW:   cut = '{65, 73, 78, 88, 97};
			DRIFT_SHRINK: cut = '{18, 28, 65, 80, 97};
			default:      cut = '{30, 42, 60, 78, 97};
		endcase
		roll = $urandom_range(0, 99);
		if (roll < cut[0])
			f = FUNC_INSERT;
		else if (roll < cut[1])
			f = FUNC_REPLACE;
		else if (roll < cut[2])
			f = FUNC_REMOVE;
		else if (roll < cut[3])
			f = FUNC_READ;
		else if (roll < cut[4])
			f = FUNC_SEARCH;
		else
			f = FUNC_W'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST));
		roll = $urandom_range(0, 99);
		if (roll < 85) begin
			if (f == FUNC_INSERT)
				p = POS_W'($urandom_range(0, list_len));
			else
				p = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
		end else if (roll < 93) begin
			p = POS_W'($urandom());
		end else begin
			case ($urandom_range(0, 2))
				0: p = POS_W'(list_len);
				1: p = NO_POSITION;
				default: p = '0;
			endcase
		end
		send_request(f, p, pick_value());
	endtask

	initial begin
		int               ph;
		int               k;
		logic [SIZE_W-1:0] s;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		value_size <= SIZE_RESET;
		in_valid <= 1'b0;
		func <= FUNC_READ;
		position <= '0;
		value_in <= '0;
		calm = 1'b0;
		stall_quiet = 1'b0;
		drift = DRIFT_GROW;
		list_len = 0;
		peak_len = 0;
		requests_sent = 0;
		size_writes = 0;
		for (k = 0; k < 8; k++)
			pool[k] = $urandom();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bounds, search hit and miss, unused codes
		write_size(SIZE_32);
		send_request(FUNC_READ, 8'd0, 32'h0);
		send_request(FUNC_REMOVE, 8'd0, 32'h0);
		send_request(FUNC_SEARCH, 8'd0, 32'h0);
		send_request(FUNC_INSERT, 8'd1, 32'h1);
		send_request(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF);
		send_request(FUNC_INSERT, 8'd0, 32'h0000_0000);
		send_request(FUNC_INSERT, 8'd2, 32'h8000_0001);
		send_request(FUNC_INSERT, NO_POSITION, 32'h5555_AAAA);
		send_request(FUNC_REPLACE, 8'd1, 32'h1234_5678);
		send_request(FUNC_REPLACE, 8'd3, 32'hAAAA_5555);
		send_request(FUNC_READ, 8'd2, 32'h0);
		send_request(FUNC_READ, NO_POSITION, 32'h0);
		send_request(FUNC_SEARCH, 8'd0, 32'h8000_0001);
		send_request(FUNC_SEARCH, 8'd0, 32'hDEAD_BEEF);
		send_request(FUNC_BAD_FIRST, 8'd0, 32'h0);
		send_request(3'd6, 8'd1, 32'h1234_5678);
		send_request(FUNC_BAD_LAST, NO_POSITION, 32'hFFFF_FFFF);
		// narrow size over wide stored entries, wide search value
		write_size(SIZE_8);
		send_request(FUNC_READ, 8'd1, 32'h0);
		send_request(FUNC_SEARCH, 8'd0, 32'h0000_0078);
		send_request(FUNC_SEARCH, 8'd0, 32'h1234_5678);
		send_request(FUNC_INSERT, 8'd0, 32'h0000_ABCD);
		write_size(SIZE_SPARE);
		send_request(FUNC_READ, 8'd0, 32'h0);
		send_request(FUNC_REMOVE, 8'd3, 32'h0);
		send_request(FUNC_REMOVE, 8'd0, 32'h0);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: s = SIZE_32;
				1: s = SIZE_8;
				2: s = SIZE_16;
				3: s = SIZE_SPARE;
				4: s = SIZE_8;
				5: s = SIZE_32;
				6: s = SIZE_16;
				default: s = SIZE_32;
			endcase
			write_size(s);
			for (k = 0; k < 8; k++)
				pool[k] = (k < 3) ? VAL_W'($urandom_range(0, 255)) : $urandom();
			stall_quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PER_PHASE; k++) begin
				if (k % DRIFT_SPAN == 0) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: drift = DRIFT_GROW;
						4, 5, 6:    drift = DRIFT_MIX;
						default:    drift = DRIFT_SHRINK;
					endcase
				end
				if (ph == PHASES - 1 && k == PER_PHASE - CALM_TAIL)
					calm = 1'b1;
				if (!calm && $urandom_range(0, 299) == 0)
					drain();
				random_request();
			end
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("covered %0d requests over %0d size writes, list length up to %0d",
			requests_sent, size_writes, peak_len);
		$display("%0d results compared, %0d searches found a match", checked, search_hits);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
